// File: hw/rtl/wilder_rsi_stream_assert.svh
// assertion macros used by the checker file of the rsi stream
`ifndef WILDER_RSI_STREAM_ASSERT_SVH
`define WILDER_RSI_STREAM_ASSERT_SVH

// antecedent and consequent in the same cycle
`define WRSI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define WRSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wrsi_pkg.sv
// shared constants and command/status types of the rsi stream
`default_nettype none

package wrsi_pkg;

  localparam int unsigned PRICE_W   = 32;
  localparam int unsigned PERIOD_W  = 8;
  localparam int unsigned CNT_W     = PERIOD_W + 1;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned AVG_W     = 56;
  localparam int unsigned SUM_W     = AVG_W - FRAC_W;
  localparam int unsigned PAD_W     = AVG_W - PRICE_W - FRAC_W;
  localparam int unsigned DIV_W     = AVG_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
  localparam int unsigned RSI_W     = 23;
  localparam int unsigned BIT_W     = $clog2(RSI_W);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
  localparam logic [RSI_W-1:0]    RSI_FULL     = RSI_W'(6553600);
  localparam logic [BIT_W-1:0]    RSI_TOP_BIT  = BIT_W'(RSI_W - 1);

  typedef enum logic {
    SEL_GAIN,
    SEL_LOSS
  } avg_sel_e;

  typedef struct packed {
    logic             load;
    logic             update;
    logic             div_start;
    logic             div_commit;
    avg_sel_e         div_sel;
    logic             div_first;
    logic             rsi_init;
    logic             rsi_a;
    logic             rsi_b;
    logic [BIT_W-1:0] bit_idx;
    logic             emit;
    logic             res_valid;
  } wrsi_cmd_t;

  typedef struct packed {
    logic first;
    logic warm;
    logic warm_last;
    logic div_done;
    logic out_busy;
  } wrsi_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/wrsi_div.sv
// serial restoring divider, one quotient bit per cycle
`default_nettype none

module wrsi_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [wrsi_pkg::DIV_W-1:0]    dividend_i,
  input  wire logic [wrsi_pkg::PERIOD_W-1:0] divisor_i,
  output logic                               done_o,
  output logic [wrsi_pkg::DIV_W-1:0]         quotient_o
);
  import wrsi_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PERIOD_W-1:0]  den_q, den_d;
  logic [PERIOD_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [PERIOD_W:0]    trial;
  logic [PERIOD_W:0]    diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W - 1);
      den_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/wrsi_dp.sv
// datapath: series state, averages, rsi bit loop and result register
`default_nettype none

module wrsi_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wrsi_pkg::PERIOD_W-1:0] cfg_wdata_i,
  input  wire logic [wrsi_pkg::PRICE_W-1:0]  price_i,
  input  wire logic                          restart_i,
  input  wire logic                          out_stall_i,
  input  wire wrsi_pkg::wrsi_cmd_t           cmd_i,
  output wrsi_pkg::wrsi_status_t             status_o,
  output logic                               out_valid_o,
  output logic                               rsi_valid_o,
  output logic [wrsi_pkg::RSI_W-1:0]         rsi_value_o
);
  import wrsi_pkg::*;

  // registered request
  logic [PRICE_W-1:0]  price_q;
  logic                restart_q;

  // series state
  logic [PERIOD_W-1:0] period_q;
  logic [PRICE_W-1:0]  prev_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [AVG_W-1:0]    gain_q;
  logic [AVG_W-1:0]    loss_q;
  logic [PRICE_W-1:0]  up_q;
  logic [PRICE_W-1:0]  down_q;

  // division bookkeeping
  logic                first_mode_q;
  logic                ge_q;

  // rsi loop
  logic [DIV_W-1:0]    s_q;
  logic [DIV_W-1:0]    r_q;
  logic [RSI_W-1:0]    q_q;

  logic                out_valid_q;
  logic                rsi_valid_q;
  logic [RSI_W-1:0]    rsi_value_q;

  logic [PERIOD_W-1:0] eff_p;
  logic                rising;
  logic [PRICE_W-1:0]  delta;
  logic [AVG_W-1:0]    sel_avg;
  logic [AVG_W-1:0]    sel_cur;
  logic                cur_ge;
  logic [DIV_W-1:0]    dividend;
  logic                div_done;
  logic [DIV_W-1:0]    quotient;
  logic [AVG_W-1:0]    quo_avg;
  logic [AVG_W-1:0]    new_avg;
  logic [DIV_W-1:0]    s_minus_r;
  logic [DIV_W-1:0]    gain_x;
  logic [DIV_W-1:0]    loss_x;

  assign eff_p  = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign rising = (price_q > prev_q);
  assign delta  = rising ? (price_q - prev_q) : (prev_q - price_q);

  assign status_o.first     = restart_q || (cnt_q == '0);
  assign status_o.warm      = (cnt_q <= {1'b0, eff_p});
  assign status_o.warm_last = (cnt_q == {1'b0, eff_p});
  assign status_o.div_done  = div_done;
  assign status_o.out_busy  = out_valid_q && out_stall_i;

  // division operands for the selected average
  assign sel_avg = (cmd_i.div_sel == SEL_LOSS) ? loss_q : gain_q;
  assign sel_cur = {{PAD_W{1'b0}}, ((cmd_i.div_sel == SEL_LOSS) ? down_q : up_q),
                    {FRAC_W{1'b0}}};
  assign cur_ge  = (sel_cur >= sel_avg);

  always_comb begin
    if (cmd_i.div_first) begin
      dividend = {1'b0, sel_avg[SUM_W-1:0], {FRAC_W{1'b0}}};
    end else if (cur_ge) begin
      dividend = {1'b0, sel_cur - sel_avg};
    end else begin
      // rounds the quotient up so the smoothed value is floored
      dividend = {1'b0, sel_avg - sel_cur} + DIV_W'(eff_p) - DIV_W'(1);
    end
  end

  wrsi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (eff_p),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign quo_avg = quotient[AVG_W-1:0];

  always_comb begin
    if (first_mode_q) begin
      new_avg = quo_avg;
    end else if (ge_q) begin
      new_avg = sel_avg + quo_avg;
    end else begin
      new_avg = sel_avg - quo_avg;
    end
  end

  assign s_minus_r = s_q - r_q;
  assign gain_x    = {1'b0, gain_q};
  assign loss_x    = {1'b0, loss_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      prev_q      <= '0;
      cnt_q       <= '0;
      gain_q      <= '0;
      loss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
        cnt_q    <= '0;
      end

      if (cmd_i.update) begin
        prev_q <= price_q;
        if (status_o.first) begin
          cnt_q  <= CNT_W'(1);
          gain_q <= '0;
          loss_q <= '0;
        end else if (status_o.warm) begin
          cnt_q <= cnt_q + 1'b1;
          if (rising) begin
            gain_q <= gain_q + AVG_W'(delta);
          end else begin
            loss_q <= loss_q + AVG_W'(delta);
          end
        end else begin
          cnt_q <= {1'b0, eff_p} + 1'b1;
        end
      end

      if (cmd_i.div_commit) begin
        if (cmd_i.div_sel == SEL_LOSS) begin
          loss_q <= new_avg;
        end else begin
          gain_q <= new_avg;
        end
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      price_q   <= price_i;
      restart_q <= restart_i;
    end

    if (cmd_i.update) begin
      up_q   <= rising ? delta : '0;
      down_q <= rising ? '0 : delta;
    end

    if (cmd_i.div_start) begin
      first_mode_q <= cmd_i.div_first;
      ge_q         <= cur_ge;
    end

    // 100 * g / (g + l) one quotient bit per two steps
    if (cmd_i.rsi_init) begin
      s_q <= gain_x + loss_x;
      r_q <= '0;
      q_q <= '0;
    end else if (cmd_i.rsi_a) begin
      if (r_q >= s_minus_r) begin
        r_q <= r_q - s_minus_r;
        q_q <= {q_q[RSI_W-2:0], 1'b1};
      end else begin
        r_q <= {r_q[DIV_W-2:0], 1'b0};
        q_q <= {q_q[RSI_W-2:0], 1'b0};
      end
    end else if (cmd_i.rsi_b && RSI_FULL[cmd_i.bit_idx]) begin
      if (r_q >= loss_x) begin
        r_q <= r_q - loss_x;
        q_q <= q_q + 1'b1;
      end else begin
        r_q <= r_q + gain_x;
      end
    end

    if (cmd_i.emit) begin
      rsi_valid_q <= cmd_i.res_valid;
      if (!cmd_i.res_valid) begin
        rsi_value_q <= '0;
      end else if (loss_q == '0) begin
        rsi_value_q <= RSI_FULL;
      end else begin
        rsi_value_q <= q_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsi_valid_o = rsi_valid_q;
  assign rsi_value_o = rsi_value_q;

endmodule

`default_nettype wire

// File: hw/rtl/wrsi_ctrl.sv
// controller: sequences update, the result and, past the warm-up sums, two divisions and the rsi loop
`default_nettype none

module wrsi_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire wrsi_pkg::wrsi_status_t status_i,
  output wrsi_pkg::wrsi_cmd_t         cmd_o
);
  import wrsi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_GSTART,
    ST_GWAIT,
    ST_LSTART,
    ST_LWAIT,
    ST_RINIT,
    ST_RA,
    ST_RB,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic             first_q, first_d;
  logic             resv_q, resv_d;
  logic [BIT_W-1:0] bit_q, bit_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    resv_d  = resv_q;
    bit_d   = bit_q;

    cmd_o           = '0;
    cmd_o.div_sel   = SEL_GAIN;
    cmd_o.div_first = first_q;
    cmd_o.res_valid = resv_q;
    cmd_o.bit_idx   = bit_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.update = 1'b1;
        if (status_i.first || (status_i.warm && !status_i.warm_last)) begin
          resv_d  = 1'b0;
          state_d = ST_EMIT;
        end else begin
          // last warm-up delta turns the sums into first averages
          resv_d  = 1'b1;
          first_d = status_i.warm_last;
          state_d = ST_GSTART;
        end
      end
      ST_GSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_GWAIT;
      end
      ST_GWAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_commit = 1'b1;
          state_d          = ST_LSTART;
        end
      end
      ST_LSTART: begin
        cmd_o.div_sel   = SEL_LOSS;
        cmd_o.div_start = 1'b1;
        state_d         = ST_LWAIT;
      end
      ST_LWAIT: begin
        cmd_o.div_sel = SEL_LOSS;
        if (status_i.div_done) begin
          cmd_o.div_commit = 1'b1;
          state_d          = ST_RINIT;
        end
      end
      ST_RINIT: begin
        cmd_o.rsi_init = 1'b1;
        bit_d          = RSI_TOP_BIT;
        state_d        = ST_RA;
      end
      ST_RA: begin
        cmd_o.rsi_a = 1'b1;
        state_d     = ST_RB;
      end
      ST_RB: begin
        cmd_o.rsi_b = 1'b1;
        if (bit_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = ST_RA;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b0;
      resv_q  <= 1'b0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      resv_q  <= resv_d;
      bit_q   <= bit_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wilder_rsi_stream.sv
// warm-up samples: the request is loaded, the series updated and the result emitted
// rsi samples: after the update the shared serial divider runs for gain, then for loss,
// then the rsi bit loop runs before the result is emitted; one request at a time, and
// the result register lets a new request in while it waits
// reset (async, active low) sets period to 14, clears the series and output valid, idles control
`default_nettype none

module wilder_rsi_stream (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wrsi_pkg::PERIOD_W-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [wrsi_pkg::PRICE_W-1:0]  price_i,
  input  wire logic                          restart_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               rsi_valid_o,
  output logic [wrsi_pkg::RSI_W-1:0]         rsi_value_o
);
  import wrsi_pkg::*;

  wrsi_cmd_t    cmd;
  wrsi_status_t status;

  wrsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wrsi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .price_i     (price_i),
    .restart_i   (restart_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .rsi_valid_o (rsi_valid_o),
    .rsi_value_o (rsi_value_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/wrsi_checker.sv
// port-level checks of the rsi stream and their bind to the top level
`default_nettype none

`include "wilder_rsi_stream_assert.svh"

module wrsi_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic [wrsi_pkg::PERIOD_W-1:0] cfg_wdata_i,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic [wrsi_pkg::PRICE_W-1:0]  price_i,
  input wire logic                          restart_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          rsi_valid_o,
  input wire logic [wrsi_pkg::RSI_W-1:0]    rsi_value_o
);
  import wrsi_pkg::*;

  logic in_take;
  logic cfg_seen;
  logic in_seen;

  assign in_take  = in_valid_i && !in_stall_o;
  assign cfg_seen = cfg_we_i && (cfg_wdata_i == cfg_wdata_i);
  assign in_seen  = in_take && (price_i == price_i) && (restart_i == restart_i);

  // one request at a time: busy right after taking one
  `WRSI_ASSERT_NEXT(a_busy_after_request, in_seen, in_stall_o,
    "stall not raised after a request")

  `WRSI_ASSERT_SAME(a_invalid_is_zero, out_valid_o && !rsi_valid_o, rsi_value_o == '0,
    "warm-up result carries a nonzero value")

  `WRSI_ASSERT_SAME(a_value_in_range, out_valid_o && rsi_valid_o, rsi_value_o <= RSI_FULL,
    "rsi above 100 percent")

  `WRSI_ASSERT_NEXT(a_result_holds, out_valid_o && out_stall_i && !cfg_seen,
    out_valid_o && $stable(rsi_value_o) && $stable(rsi_valid_o),
    "stalled result changed")

endmodule

bind wilder_rsi_stream wrsi_checker u_checker (.*);

`default_nettype wire
